### design/pclpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pclpc_pkg: shared types and constants for uplink closed-loop power control
// Request and response words, register file layout and register indexes.
// ----------------------------------------------------------------------------
package pclpc_pkg;

   localparam int DB_FRAC_BITS_DEF = 6;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_NOMINAL_POWER   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POWER       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATHLOSS_WEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_FLOOR     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINR_GOAL       = 3'd4;

   typedef struct packed {
      logic [13:0] path_loss;
      logic        clear_accum;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] tx_power_closed;
      logic signed [15:0] tx_power_open;
      logic signed [15:0] sinr_closed;
      logic signed [15:0] sinr_open;
      logic signed [11:0] accum_used;
      logic signed [2:0]  tpc_step;
      logic               at_ceiling;
   } rsp_word_type;

   typedef struct packed {
      logic signed [14:0] nominal_power;
      logic signed [14:0] max_power;
      logic        [8:0]  pathloss_weight;
      logic signed [14:0] noise_floor;
      logic signed [12:0] sinr_goal;
   } cfg_type;

   // accumulator width: holds +/-30 dB with sign
   function automatic int acc_width(input int frac_bits);
      return $clog2(30 * (1 << frac_bits) + 1) + 1;
   endfunction

endpackage
`default_nettype wire

### design/pusch_closed_loop_power_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pusch_closed_loop_power_ctrl: uplink power control with accumulated TPC
// Path: an accepted request is held in the input register and then loaded into
// the response register, which waits while the response output is stalled.
// Throughput: one word per cycle while rsp_stall is low; the TPC accumulator
// loop closes between the input register and the response register.
// Reset: synchronous; clears both valid stages and the accumulator and loads
// the register defaults.
// ----------------------------------------------------------------------------
module pusch_closed_loop_power_ctrl #(
   parameter int DB_FRAC_BITS = pclpc_pkg::DB_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pclpc_pkg::req_word_type               req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pclpc_pkg::rsp_word_type               rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pclpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pclpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pclpc_pkg::*;

   localparam int ACC_W = acc_width(DB_FRAC_BITS);

   cfg_type                 cfg_ff, cfg_in;
   logic                    s1_valid_ff;
   req_word_type            s1_word_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;
   rsp_word_type            rsp_word_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] acc_eff;
   logic                    s2_load;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // advance stage one into the response register when it is free or draining
   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s2_load;
   assign acc_eff   = s1_word_ff.clear_accum ? '0 : acc_ff;

   pclpc_core #(
      .DB_FRAC_BITS (DB_FRAC_BITS)
   ) u_core (
      .cfg      (cfg_ff),
      .word     (s1_word_ff),
      .acc      (acc_eff),
      .rsp      (rsp_word_in),
      .acc_next (acc_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NOMINAL_POWER:   cfg_in.nominal_power   = csr_wdata[14:0];
            CSR_MAX_POWER:       cfg_in.max_power       = csr_wdata[14:0];
            CSR_PATHLOSS_WEIGHT: cfg_in.pathloss_weight = csr_wdata[8:0];
            CSR_NOISE_FLOOR:     cfg_in.noise_floor     = csr_wdata[14:0];
            CSR_SINR_GOAL:       cfg_in.sinr_goal       = csr_wdata[12:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_power   <= 15'sd0;
         cfg_ff.max_power       <= 15'sd1472;
         cfg_ff.pathloss_weight <= 9'd256;
         cfg_ff.noise_floor     <= -15'sd7552;
         cfg_ff.sinr_goal       <= 13'sd0;
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         acc_ff                 <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (!s1_valid_ff || s2_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_word;
      end
      if (s2_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
`default_nettype wire

### design/pclpc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pclpc_core: single-pass power and SINR datapath
// Open/closed-loop power, SINR, TPC step selection and clamped accumulate.
// ----------------------------------------------------------------------------
module pclpc_core #(
   parameter  int DB_FRAC_BITS = pclpc_pkg::DB_FRAC_BITS_DEF,
   localparam int ACC_W        = pclpc_pkg::acc_width(DB_FRAC_BITS)
) (
   input  pclpc_pkg::cfg_type      cfg,
   input  pclpc_pkg::req_word_type word,
   input  logic signed [ACC_W-1:0] acc,
   output pclpc_pkg::rsp_word_type rsp,
   output logic signed [ACC_W-1:0] acc_next
);
   import pclpc_pkg::*;

   localparam int CALC_W    = ((ACC_W > 17) ? ACC_W : 17) + 4;
   localparam int ONE_DB_I  = 1 << DB_FRAC_BITS;
   localparam int HALF_DB_I = ONE_DB_I / 2;
   localparam int ACC_LIM_I = 30 * ONE_DB_I;

   localparam logic signed [CALC_W-1:0] ONE_DB    = CALC_W'(ONE_DB_I);
   localparam logic signed [CALC_W-1:0] THREE_DB  = CALC_W'(3 * ONE_DB_I);
   localparam logic signed [CALC_W-1:0] HALF_DB   = CALC_W'(HALF_DB_I);
   localparam logic signed [CALC_W-1:0] N_HALF_DB = CALC_W'(-HALF_DB_I);
   localparam logic signed [CALC_W-1:0] ACC_LIM   = CALC_W'(ACC_LIM_I);
   localparam logic signed [CALC_W-1:0] N_ACC_LIM = CALC_W'(-ACC_LIM_I);

   localparam logic signed [2:0] STEP_UP3  = 3'sd3;
   localparam logic signed [2:0] STEP_UP1  = 3'sd1;
   localparam logic signed [2:0] STEP_HOLD = 3'sd0;
   localparam logic signed [2:0] STEP_DN1  = -3'sd1;

   localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'(32767);
   localparam logic signed [CALC_W-1:0] SAT_LO = CALC_W'(-32768);

   function automatic logic signed [15:0] sat16(input logic signed [CALC_W-1:0] v);
      if (v > SAT_HI) begin
         return 16'sh7fff;
      end else if (v < SAT_LO) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   logic        [22:0]       prod;
   logic signed [CALC_W-1:0] acc_x;
   logic signed [CALC_W-1:0] pl_x;
   logic signed [CALC_W-1:0] ol;
   logic signed [CALC_W-1:0] pmax;
   logic signed [CALC_W-1:0] nf;
   logic signed [CALC_W-1:0] open_p;
   logic signed [CALC_W-1:0] raw;
   logic signed [CALC_W-1:0] closed_p;
   logic signed [CALC_W-1:0] s_open;
   logic signed [CALC_W-1:0] s_closed;
   logic signed [CALC_W-1:0] err;
   logic signed [CALC_W-1:0] step_amt;
   logic signed [CALC_W-1:0] sum;
   logic signed [CALC_W-1:0] clamped;
   logic signed [2:0]        step;

   always_comb begin
      prod     = 23'(cfg.pathloss_weight) * 23'(word.path_loss);
      acc_x    = CALC_W'(acc);
      pl_x     = signed'(CALC_W'(word.path_loss));
      pmax     = CALC_W'(cfg.max_power);
      nf       = CALC_W'(cfg.noise_floor);
      ol       = CALC_W'(cfg.nominal_power) + signed'(CALC_W'(prod[22:8]));
      open_p   = (ol < pmax) ? ol : pmax;
      raw      = ol + acc_x;
      closed_p = (raw < pmax) ? raw : pmax;
      s_open   = open_p - pl_x - nf;
      s_closed = closed_p - pl_x - nf;
      err      = CALC_W'(cfg.sinr_goal) - s_closed;

      if (err > THREE_DB) begin
         step     = STEP_UP3;
         step_amt = THREE_DB;
      end else if (err > HALF_DB) begin
         step     = STEP_UP1;
         step_amt = ONE_DB;
      end else if (err < N_HALF_DB) begin
         step     = STEP_DN1;
         step_amt = -ONE_DB;
      end else begin
         step     = STEP_HOLD;
         step_amt = '0;
      end

      sum = acc_x + step_amt;
      if (sum > ACC_LIM) begin
         clamped = ACC_LIM;
      end else if (sum < N_ACC_LIM) begin
         clamped = N_ACC_LIM;
      end else begin
         clamped = sum;
      end
      acc_next = ACC_W'(clamped);

      rsp.tx_power_closed = sat16(closed_p);
      rsp.tx_power_open   = sat16(open_p);
      rsp.sinr_closed     = sat16(s_closed);
      rsp.sinr_open       = sat16(s_open);
      rsp.accum_used      = 12'(acc);
      rsp.tpc_step        = step;
      rsp.at_ceiling      = (raw > pmax);
   end

endmodule
`default_nettype wire
